// File: rtl/core/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types and constants for the frequency rank substitution block:
// transfer payloads, sequencer states and the two substitution tables.
// ----------------------------------------------------------------------------
package frs_pkg;

    // alphabet and letter codes
    localparam int ALPHA_N = 26;
    localparam int LIDX_W  = 5;
    localparam int CNT_W   = 7;
    localparam logic [7:0] LETTER_A = 8'd65;
    localparam logic [7:0] LETTER_Z = 8'd90;
    localparam logic [LIDX_W-1:0] LAST_LETTER = LIDX_W'(ALPHA_N - 1);

    // input transfer payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    // output transfer payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       overflowed;
    } out_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RANK_FETCH,
        ST_RANK_CMP,
        ST_READ,
        ST_FORM,
        ST_OUT
    } state_t;

    // rank to letter, english frequency order
    localparam logic [7:0] DEC_TABLE [ALPHA_N] = '{
        "E","T","A","I","O","N","S","R","H","D","L","U","C",
        "M","F","Y","W","G","P","B","V","K","X","Q","J","Z"
    };

    // rank to letter, fixed encrypt order
    localparam logic [7:0] ENC_TABLE [ALPHA_N] = '{
        "J","I","C","A","X","S","E","Y","V","D","K","W","B",
        "Q","T","Z","R","H","F","M","P","N","U","L","G","O"
    };

endpackage

// File: rtl/core/frequency_rank_substitution_top.sv
// ----------------------------------------------------------------------------
// frequency_rank_substitution_top
// Buffers a text, counts its uppercase letters, ranks the letters by count
// and replays the text with each letter replaced by the table entry at its rank.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    in_data  (in_byte, in_last)
//  out       source     out_valid / out_stall  out_data (out_byte, out_last, overflowed)
//  cfg       sink       cfg_wr_en              cfg_wr_data (mode)
//
//  loading takes one byte per cycle; in_stall is low only while loading
//  after the last byte, one shared comparator ranks the letters: it walks
//  every counter once per letter
//  emission then reads the text memory, forms the substitution and loads
//  the output register for one result before it starts the next; out_stall holds the output register
//  reset clears counters, length, overflow flag and sets mode to decrypt
//
module frequency_rank_substitution_top #(
    parameter int MAX_LEN = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  frs_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output frs_pkg::out_t out_data,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data
);
    import frs_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);

    // state and control registers
    state_t state_reg, state_next;
    logic   mode_reg;
    logic [LW-1:0] len_reg, len_next;
    logic   ovf_reg, ovf_next;
    logic [LIDX_W-1:0] letter_reg, letter_next;
    logic [LIDX_W-1:0] cmp_reg, cmp_next;
    logic [CNT_W-1:0]  cur_cnt_reg, cur_cnt_next;
    logic [LIDX_W-1:0] rank_reg, rank_next;
    logic [AW-1:0]     emit_reg, emit_next;

    // storage
    logic [7:0]       text_mem [MAX_LEN];
    logic [7:0]       mem_rd_reg;
    logic [CNT_W-1:0] cnt_reg [ALPHA_N];
    logic [7:0]       sub_reg [ALPHA_N];
    out_t             out_reg, out_next;

    // combinational helpers
    logic              in_xfer, out_xfer, full, in_letter, store_en;
    logic [LIDX_W-1:0] in_idx, cnt_addr;
    logic [CNT_W-1:0]  cnt_rd;
    logic              cmp_hit, cmp_done, emit_last, rd_letter;
    logic [LIDX_W-1:0] rank_sum;
    logic              cnt_inc, text_done;
    logic [7:0]        sub_byte;

    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;
    assign full      = (len_reg == LW'(MAX_LEN));
    assign in_letter = (in_data.in_byte >= LETTER_A) && (in_data.in_byte <= LETTER_Z);
    assign in_idx    = LIDX_W'(in_data.in_byte - LETTER_A);
    assign store_en  = in_xfer && !full;
    assign cnt_inc   = store_en && in_letter;
    assign text_done = out_xfer && out_reg.out_last;

    // single read port on the letter counters
    always_comb
    begin
        case (state_reg)
            ST_LOAD:       cnt_addr = in_idx;
            ST_RANK_FETCH: cnt_addr = letter_reg;
            default:       cnt_addr = cmp_reg;
        endcase
    end
    assign cnt_rd = cnt_reg[cnt_addr];

    // shared compare unit: does letter m outrank the current letter
    assign cmp_hit  = (cnt_rd > cur_cnt_reg) ||
                      ((cnt_rd == cur_cnt_reg) && (cmp_reg > letter_reg));
    assign rank_sum = rank_reg + LIDX_W'(cmp_hit);
    assign cmp_done = (cmp_reg == LAST_LETTER);

    // emission helpers
    assign emit_last = ((LW'(emit_reg) + LW'(1)) == len_reg);
    assign rd_letter = (mem_rd_reg >= LETTER_A) && (mem_rd_reg <= LETTER_Z);
    assign sub_byte  = sub_reg[LIDX_W'(mem_rd_reg - LETTER_A)];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer && in_data.in_last)
                    state_next = ST_RANK_FETCH;
            end
            ST_RANK_FETCH:
            begin
                state_next = ST_RANK_CMP;
            end
            ST_RANK_CMP:
            begin
                if (cmp_done)
                    state_next = (letter_reg == LAST_LETTER) ? ST_READ : ST_RANK_FETCH;
            end
            ST_READ:
            begin
                state_next = ST_FORM;
            end
            ST_FORM:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_xfer)
                    state_next = out_reg.out_last ? ST_LOAD : ST_READ;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_LOAD: in_stall  = 1'b0;
            ST_OUT:  out_valid = 1'b1;
            default:
            begin
                in_stall  = 1'b1;
                out_valid = 1'b0;
            end
        endcase
    end
    assign out_data = out_reg;

    // datapath next values
    always_comb
    begin
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        letter_next  = letter_reg;
        cmp_next     = cmp_reg;
        cur_cnt_next = cur_cnt_reg;
        rank_next    = rank_reg;
        emit_next    = emit_reg;
        out_next     = out_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (store_en)
                    len_next = len_reg + LW'(1);
                if (in_xfer && full)
                    ovf_next = 1'b1;
                letter_next = '0;
            end
            ST_RANK_FETCH:
            begin
                cur_cnt_next = cnt_rd;
                rank_next    = '0;
                cmp_next     = '0;
            end
            ST_RANK_CMP:
            begin
                rank_next = rank_sum;
                cmp_next  = cmp_reg + LIDX_W'(1);
                if (cmp_done)
                begin
                    letter_next = letter_reg + LIDX_W'(1);
                    emit_next   = '0;
                end
            end
            ST_FORM:
            begin
                out_next.out_byte   = rd_letter ? sub_byte : mem_rd_reg;
                out_next.out_last   = emit_last;
                out_next.overflowed = ovf_reg;
            end
            ST_OUT:
            begin
                if (out_xfer)
                begin
                    emit_next = emit_reg + AW'(1);
                    if (out_reg.out_last)
                    begin
                        len_next = '0;
                        ovf_next = 1'b0;
                    end
                end
            end
            default:
            begin
                len_next = len_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            mode_reg  <= 1'b0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
        end
    end

    // sequencer payload registers
    always_ff @(posedge clk)
    begin
        letter_reg  <= letter_next;
        cmp_reg     <= cmp_next;
        cur_cnt_reg <= cur_cnt_next;
        rank_reg    <= rank_next;
        emit_reg    <= emit_next;
        out_reg     <= out_next;
    end

    // letter counters, cleared once the final result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHA_N; i++)
                cnt_reg[i] <= '0;
        end
        else if (text_done)
        begin
            for (int i = 0; i < ALPHA_N; i++)
                cnt_reg[i] <= '0;
        end
        else if (cnt_inc)
        begin
            cnt_reg[cnt_addr] <= cnt_rd + CNT_W'(1);
        end
    end

    // substitution per letter, written when its rank is known
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RANK_CMP && cmp_done)
            sub_reg[letter_reg] <= mode_reg ? ENC_TABLE[rank_sum] : DEC_TABLE[rank_sum];
    end

    // text memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (store_en)
            text_mem[len_reg[AW-1:0]] <= in_data.in_byte;
        mem_rd_reg <= text_mem[emit_reg];
    end

endmodule

// File: tb/tb_frequency_rank_substitution_top.sv
// ----------------------------------------------------------------------------
// tb_frequency_rank_substitution_top
// Self-checking bench for the frequency rank substitution block: texts are
// sent byte by byte, a local letter-ranking predictor builds the expected
// substituted text and every output transfer is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frequency_rank_substitution_top;

    import frs_pkg::*;

    localparam int TEXT_CAP       = 64;
    localparam int ITEM_GOAL      = 410;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 8000;

    // rank to letter, kept locally for prediction
    localparam logic [7:0] FREQ_ORDER [ALPHA_N] = '{
        "E","T","A","I","O","N","S","R","H","D","L","U","C",
        "M","F","Y","W","G","P","B","V","K","X","Q","J","Z"
    };
    localparam logic [7:0] CIPHER_ORDER [ALPHA_N] = '{
        "J","I","C","A","X","S","E","Y","V","D","K","W","B",
        "Q","T","Z","R","H","F","M","P","N","U","L","G","O"
    };

    logic clk;
    logic rst_n;
    logic in_valid    = 1'b0;
    logic in_stall;
    in_t  in_data     = '0;
    logic out_valid;
    logic out_stall   = 1'b0;
    out_t out_data;
    logic cfg_wr_en   = 1'b0;
    logic cfg_wr_data = 1'b0;

    // predictor state
    logic [7:0]       text_buf [TEXT_CAP];
    logic [CNT_W-1:0] letter_tally [ALPHA_N];
    int               text_len;
    logic             text_dropped;
    logic             cipher_mode;
    out_t             expected_chars [$];

    // stimulus bookkeeping
    logic [7:0] pending_text [$];
    int         burst_left;
    int         random_chars_sent;
    int         error_count;
    int         idle_cycles;
    int         stall_pct;
    int         stall_seg_left;

    frequency_rank_substitution_top #(
        .MAX_LEN (TEXT_CAP)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // rank letters and queue the substituted text, then start a new text
    function automatic void emit_substitution();
        logic [7:0] sub_letter [ALPHA_N];
        int         rank;
        logic [7:0] c;
        out_t       item;
        for (int l = 0; l < ALPHA_N; l++)
        begin
            rank = 0;
            for (int m = 0; m < ALPHA_N; m++)
            begin
                if (letter_tally[m] > letter_tally[l] ||
                    (letter_tally[m] == letter_tally[l] && m > l))
                    rank++;
            end
            sub_letter[l] = cipher_mode ? CIPHER_ORDER[rank] : FREQ_ORDER[rank];
        end
        for (int i = 0; i < text_len; i++)
        begin
            c = text_buf[i];
            item.out_byte   = (c >= LETTER_A && c <= LETTER_Z) ? sub_letter[c - LETTER_A] : c;
            item.out_last   = (i == text_len - 1);
            item.overflowed = text_dropped;
            expected_chars.push_back(item);
        end
        for (int l = 0; l < ALPHA_N; l++)
            letter_tally[l] = '0;
        text_len     = 0;
        text_dropped = 1'b0;
    endfunction

    // store and count one accepted byte; a full buffer drops it
    function automatic void absorb_char(input logic [7:0] b, input logic last);
        if (text_len >= TEXT_CAP)
            text_dropped = 1'b1;
        else
        begin
            text_buf[text_len] = b;
            text_len++;
            if (b >= LETTER_A && b <= LETTER_Z)
                letter_tally[b - LETTER_A] = letter_tally[b - LETTER_A] + CNT_W'(1);
        end
        if (last)
            emit_substitution();
    endfunction

    // send pending_text as one text, in bursts with random gaps
    task automatic send_text();
        int gap;
        int n;
        n = pending_text.size();
        for (int i = 0; i < n; i++)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 16);
            end
            in_data  <= '{in_byte: pending_text[i], in_last: (i == n - 1)};
            in_valid <= 1'b1;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            absorb_char(pending_text[i], i == n - 1);
            burst_left--;
        end
        in_valid <= 1'b0;
        pending_text.delete();
        @(posedge clk);
    endtask

    // mode write once the block has drained and settled
    task automatic set_mode(input logic m);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_data <= m;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cipher_mode = m;
    endtask

    // boundary byte values, letters at both ends of the alphabet
    task automatic test_byte_extremes();
        set_mode(1'b0);
        pending_text = '{8'h00, 8'hFF, "@", "[", "a", "A", "Z", "Z"};
        send_text();
    endtask

    // texts made of the last byte alone
    task automatic test_single_char_text();
        set_mode(1'b1);
        pending_text = '{"Q"};
        send_text();
        pending_text = '{8'h7F};
        send_text();
    endtask

    // equal counts, later letter must rank first
    task automatic test_count_ties();
        pending_text = '{"B", "B", "A", "A", "C", "C", "D"};
        send_text();
        set_mode(1'b0);
        pending_text = '{"B", "B", "A", "A", "C", "C", "D"};
        send_text();
    endtask

    // exactly full, full with the last byte dropped, and well past full
    task automatic test_buffer_limits();
        int lens [3];
        lens = '{TEXT_CAP, TEXT_CAP + 1, TEXT_CAP + 7};
        foreach (lens[k])
        begin
            repeat (lens[k])
                pending_text.push_back(($urandom_range(0, 3) == 0) ?
                    8'($urandom_range(0, 255)) : LETTER_A + 8'($urandom_range(0, 25)));
            random_chars_sent += lens[k];
            send_text();
        end
    endtask

    // random texts, mostly short, letters drawn from a random span
    task automatic test_random_texts();
        int         len;
        int         span;
        logic [7:0] b;
        while (random_chars_sent < ITEM_GOAL)
        begin
            if ($urandom_range(0, 3) == 0)
                set_mode(1'($urandom_range(0, 1)));
            len  = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 72) : $urandom_range(1, 20);
            span = $urandom_range(0, 25);
            repeat (len)
            begin
                if ($urandom_range(0, 4) == 0)
                    b = 8'($urandom_range(0, 255));
                else
                    b = LETTER_A + 8'($urandom_range(0, span));
                pending_text.push_back(b);
            end
            random_chars_sent += len;
            send_text();
        end
    endtask

    // output check and receiver stall pattern
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected output transfer: out_byte %h", out_data.out_byte);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_data.out_byte !== want.out_byte)
                begin
                    $error("out_byte expected %h actual %h", want.out_byte, out_data.out_byte);
                    error_count++;
                end
                if (out_data.out_last !== want.out_last)
                begin
                    $error("out_last expected %b actual %b", want.out_last, out_data.out_last);
                    error_count++;
                end
                if (out_data.overflowed !== want.overflowed)
                begin
                    $error("overflowed expected %b actual %b",
                           want.overflowed, out_data.overflowed);
                    error_count++;
                end
            end
        end
        // stall density changes from segment to segment, zero included
        if (stall_seg_left == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            stall_seg_left = $urandom_range(20, 300);
        end
        else
            stall_seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        text_len          = 0;
        text_dropped      = 1'b0;
        cipher_mode       = 1'b0;
        burst_left        = 0;
        random_chars_sent = 0;
        error_count       = 0;
        idle_cycles       = 0;
        stall_pct         = 0;
        stall_seg_left    = 0;
        for (int l = 0; l < ALPHA_N; l++)
            letter_tally[l] = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_byte_extremes();
        test_single_char_text();
        test_count_ties();
        test_buffer_limits();
        test_random_texts();

        // drain, then leave room for any stray transfer
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
